>>> rtl/phxm_pkg.sv
package phxm_pkg;

  // Command codes carried by an input word.
  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_ABSORB  = 2'd1;
  localparam logic [1:0] CMD_APPLY   = 2'd2;

  localparam int unsigned FLAG_SHIFT  = 3;
  localparam int unsigned FLAG_BITS   = 5;
  localparam int unsigned FLAG_PIXELS = 2;
  localparam int unsigned MAX_COUNT   = 16;
  localparam logic [3:0]  LOW_BITS_RESET = 4'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;           // input word accepted
    logic rd;             // read the mask byte under the index
    logic step;           // process one chunk with the byte just read
    logic finish_absorb;  // absorb done, apply end-of-image clear
    logic out_load;       // move the finished value into the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_work;   // offered word is an absorb or apply
    logic rem_zero;  // no bits left for the word in hand
    logic is_apply;  // word in hand is an apply
    logic out_free;  // result register can take a value this cycle
  } dp_status_t;

  // Low n bits set, n from 0 to 8.
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    low_mask = 8'hFF >> (4'd8 - n);
  endfunction

  // Restart pattern for a mask byte, from the byte number modulo 8.
  function automatic logic [7:0] restart_byte(input logic [2:0] k);
    restart_byte = 8'hFF >> (3'd7 - k);
  endfunction

endpackage

>>> rtl/phxm_if.sv
interface phxm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  pixel_byte;
  logic        end_of_image;
  logic [15:0] data_value;
  logic [4:0]  bit_count;

  modport source (
    output valid, command, pixel_byte, end_of_image, data_value, bit_count,
    input  ready
  );
  modport sink (
    input  valid, command, pixel_byte, end_of_image, data_value, bit_count,
    output ready
  );
endinterface

interface phxm_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] masked_value;

  modport source (output valid, masked_value, input ready);
  modport sink (input valid, masked_value, output ready);
endinterface

>>> rtl/phxm_ctrl.sv
module phxm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  phxm_pkg::dp_status_t status,
  output phxm_pkg::ctrl_cmd_t  cmd
);
  import phxm_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid && status.in_work) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!status.rem_zero) begin
          state_next = S_EXEC;
        end else if (!status.is_apply || status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EXEC: begin
        state_next = S_RUN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.load = item_valid;
      end
      S_RUN: begin
        if (!status.rem_zero) begin
          cmd.rd = 1'b1;
        end else if (!status.is_apply) begin
          cmd.finish_absorb = 1'b1;
        end else begin
          // A previous result that is still waiting holds the finished value here.
          cmd.out_load = status.out_free;
        end
      end
      S_EXEC: begin
        cmd.step = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_out_load_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (status.out_free && status.is_apply && status.rem_zero))
    else $error("result loaded while register busy or work left");

  a_exec_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $past(cmd.rd))
    else $error("chunk step without a preceding mask read");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd, cmd.step, cmd.finish_absorb, cmd.out_load}))
    else $error("more than one datapath command at once");

endmodule

>>> rtl/phxm_dp.sv
module phxm_dp #(
  parameter int unsigned MASK_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [3:0]           cfg_data,
  input  logic [1:0]           item_command,
  input  logic [7:0]           item_pixel_byte,
  input  logic                 item_end_of_image,
  input  logic [15:0]          item_data_value,
  input  logic [4:0]           item_bit_count,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [15:0]          result_masked_value,
  input  phxm_pkg::ctrl_cmd_t  cmd,
  output phxm_pkg::dp_status_t status
);
  import phxm_pkg::*;

  localparam int unsigned TOTAL_BITS = MASK_BYTES * 8;
  localparam int unsigned IW = $clog2(TOTAL_BITS);
  localparam int unsigned AW = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
  localparam logic [IW:0] TOTAL_W = (IW + 1)'(TOTAL_BITS);

  logic [3:0]            low_bits;
  logic [7:0]            mem [MASK_BYTES];
  logic [MASK_BYTES-1:0] valid;
  logic [IW-1:0]         bit_index;
  logic [1:0]            flag_pixels_seen;

  // Word in hand.
  logic        work_apply;
  logic        work_eoi;
  logic [7:0]  work_src;
  logic [15:0] work_acc;
  logic [4:0]  work_rem;
  logic [4:0]  work_off;

  logic [7:0]  rd_q;
  logic        rd_valid_q;
  logic [7:0]  rd_pat_q;
  logic [7:0]  rd_byte;

  logic [IW-1:0] byte_sel;
  logic [AW-1:0] addr;
  logic [2:0]    pos;
  logic [3:0]    room;
  logic [3:0]    n;
  logic [7:0]    nmask;
  logic [7:0]    wbyte;
  logic [15:0]   acc_chunk;
  logic [IW:0]   idx_sum;
  logic [IW:0]   idx_wrap;
  logic [4:0]    count_sat;
  logic          is_restart;

  assign byte_sel = bit_index >> 3;
  assign addr     = byte_sel[AW-1:0];
  assign pos      = bit_index[2:0];
  assign room     = 4'd8 - {1'b0, pos};
  assign n        = ({1'b0, room} > work_rem) ? work_rem[3:0] : room;
  assign nmask    = low_mask(n);

  // A byte not written since restart still reads as its restart pattern.
  assign rd_byte   = rd_valid_q ? rd_q : rd_pat_q;
  assign wbyte     = rd_byte ^ ((work_src & nmask) << pos);
  assign acc_chunk = {8'b0, rd_byte & nmask} << work_off[3:0];

  assign idx_sum  = {1'b0, bit_index} + (IW + 1)'(n);
  assign idx_wrap = (idx_sum >= TOTAL_W) ? (idx_sum - TOTAL_W) : idx_sum;

  assign count_sat  = (item_bit_count > 5'(MAX_COUNT)) ? 5'(MAX_COUNT) : item_bit_count;
  assign is_restart = cmd.load && (item_command == CMD_RESTART);

  assign status.in_work  = (item_command == CMD_ABSORB) || (item_command == CMD_APPLY);
  assign status.rem_zero = (work_rem == 5'd0);
  assign status.is_apply = work_apply;
  assign status.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bits <= LOW_BITS_RESET;
    end else if (cfg_write) begin
      low_bits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid            <= '0;
      bit_index        <= '0;
      flag_pixels_seen <= '0;
      work_rem         <= '0;
    end else begin
      if (cmd.load) begin
        case (item_command)
          CMD_RESTART: begin
            valid            <= '0;
            bit_index        <= '0;
            flag_pixels_seen <= '0;
          end
          CMD_ABSORB: begin
            if (flag_pixels_seen < 2'(FLAG_PIXELS)) begin
              work_rem         <= 5'(FLAG_BITS);
              flag_pixels_seen <= flag_pixels_seen + 2'd1;
            end else if (low_bits < 4'd8) begin
              work_rem <= 5'd8 - {1'b0, low_bits};
            end else begin
              work_rem <= 5'd0;
            end
          end
          CMD_APPLY: begin
            work_rem <= count_sat;
          end
          default: begin
          end
        endcase
      end
      if (cmd.step) begin
        bit_index <= idx_wrap[IW-1:0];
        work_rem  <= work_rem - {1'b0, n};
        if (!work_apply) begin
          valid[addr] <= 1'b1;
        end
      end
      if (cmd.finish_absorb && work_eoi) begin
        bit_index <= '0;
      end
    end
  end

  // Payload of the word in hand.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_apply <= (item_command == CMD_APPLY);
      work_eoi   <= item_end_of_image;
      work_acc   <= item_data_value;
      work_off   <= 5'd0;
      if (flag_pixels_seen < 2'(FLAG_PIXELS)) begin
        work_src <= item_pixel_byte >> FLAG_SHIFT;
      end else begin
        work_src <= item_pixel_byte >> low_bits;
      end
    end else if (cmd.step) begin
      work_src <= work_src >> n;
      work_acc <= work_acc ^ acc_chunk;
      work_off <= work_off + {1'b0, n};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && !work_apply) begin
      mem[addr] <= wbyte;
    end
    if (cmd.rd) begin
      rd_q       <= mem[addr];
      rd_valid_q <= valid[addr];
      rd_pat_q   <= restart_byte(byte_sel[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_masked_value <= work_acc;
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    is_restart |=> (bit_index == '0) && (flag_pixels_seen == 2'd0) && (valid == '0))
    else $error("restart did not clear index, flag count and mask");

  a_step_has_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (work_rem != 5'd0) && (n != 4'd0))
    else $error("chunk step with no bits left");

  a_index_in_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> ({1'b0, bit_index} < TOTAL_W))
    else $error("bit index left the mask ring");

endmodule

>>> rtl/pixel_hash_xor_mask_core.sv
// Channel   Role   Payload
// item      sink   command, pixel_byte, end_of_image, data_value, bit_count
// result    source masked_value
// cfg       write  low_bits (cfg_write, cfg_data)
//
// Restart and unused words are taken in idle with nothing more to do. Absorb and apply words
// then run chunk by chunk (a mask byte read, then the step on it; absorb writes the byte back).
// Each chunk reads the mask memory once; no new word is accepted until the word in hand ends.
// Reset and restart bring back the mask pattern at once by clearing per-byte valid bits.
// A finished result waits in its register while the next word is accepted; an apply that
// finishes while the register is still full holds until the result word is taken.
module pixel_hash_xor_mask_core #(
  parameter int unsigned MASK_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [3:0]    cfg_data,
  phxm_item_if.sink     item,
  phxm_result_if.source result
);
  import phxm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  phxm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  phxm_dp #(
    .MASK_BYTES (MASK_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_data            (cfg_data),
    .item_command        (item.command),
    .item_pixel_byte     (item.pixel_byte),
    .item_end_of_image   (item.end_of_image),
    .item_data_value     (item.data_value),
    .item_bit_count      (item.bit_count),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_masked_value (result.masked_value),
    .cmd                 (cmd),
    .status              (status)
  );

endmodule
